// ===== rtl/zdf_pkg.sv =====
package zdf_pkg;

    // Number of channels with their own filter state.
    localparam int CHANNELS = 8;
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int ST_W     = 28;
    localparam int STAGES   = 4;
    localparam int STAGE_W  = 2;
    localparam int FRAC_W   = 16;
    localparam int DIFF_W   = ST_W + 1;
    localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W    = 32;
    localparam int STATE_WORD_W = STAGES * ST_W;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FEEDBACK_GAIN = 1'b0;
    localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RESET = 16'd26214;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGES - 1);

    typedef struct packed {
        logic                load;
        logic                fb_mul;
        logic                fb_sub;
        logic                st_mul;
        logic                st_upd;
        logic [STAGE_W-1:0]  stage;
        logic                wb;
    } dp_cmd_t;

    typedef struct packed {
        logic chan_bad;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [CH_W-1:0] ch);
        return ADDR_W'(ch);
    endfunction

    function automatic logic chan_ok(input logic [CH_W-1:0] ch);
        return (32'(ch) < CHANNELS);
    endfunction

    // Saturate a wide sum to the signed state width.
    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (ST_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return hi[ST_W-1:0];
        else if (v < lo)
            return lo[ST_W-1:0];
        else
            return v[ST_W-1:0];
    endfunction

    // Saturate a state-width value to the signed sample width.
    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [ST_W-1:0] v);
        logic signed [ST_W-1:0] hi;
        logic signed [ST_W-1:0] lo;
        hi = ST_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
        lo = -hi - ST_W'(1);
        if (v > hi)
            return hi[SAMPLE_W-1:0];
        else if (v < lo)
            return lo[SAMPLE_W-1:0];
        else
            return v[SAMPLE_W-1:0];
    endfunction

    // Round a Q0.16 product to nearest, halves toward plus infinity.
    function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        logic signed [PROD_W:0] s;
        t = $signed({p[PROD_W-1], p}) + $signed((PROD_W + 1)'(1) <<< (FRAC_W - 1));
        s = t >>> FRAC_W;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_st(input logic signed [ST_W-1:0] v);
        return $signed({{(ACC_W - ST_W){v[ST_W-1]}}, v});
    endfunction

endpackage

// ===== rtl/zdf_ram.sv =====
module zdf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/zdf_ctrl.sv =====
module zdf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  zdf_pkg::dp_status_t status,
    output zdf_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FB_MUL,
        S_FB_SUB,
        S_ST_MUL,
        S_ST_UPD,
        S_WB
    } state_t;

    state_t                       state_reg, state_next;
    logic [zdf_pkg::STAGE_W-1:0]  stage_reg, stage_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         wb_go;

    // The result slot is free when empty or emptied in this cycle.
    assign wb_go = (state_reg == S_WB) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_FB_MUL;
                end
            end
            S_FB_MUL:
            begin
                state_next = status.chan_bad ? S_WB : S_FB_SUB;
            end
            S_FB_SUB:
            begin
                stage_next = '0;
                state_next = S_ST_MUL;
            end
            S_ST_MUL:
            begin
                state_next = S_ST_UPD;
            end
            S_ST_UPD:
            begin
                if (stage_reg == zdf_pkg::LAST_STAGE)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = S_ST_MUL;
                end
            end
            S_WB:
            begin
                if (wb_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.fb_mul = (state_reg == S_FB_MUL);
        cmd.fb_sub = (state_reg == S_FB_SUB);
        cmd.st_mul = (state_reg == S_ST_MUL);
        cmd.st_upd = (state_reg == S_ST_UPD);
        cmd.stage  = stage_reg;
        cmd.wb     = wb_go;
    end

endmodule

// ===== rtl/zdf_datapath.sv =====
module zdf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  zdf_pkg::dp_cmd_t                    cmd,
    output zdf_pkg::dp_status_t                 status,
    input  logic [zdf_pkg::GAIN_W-1:0]          feedback_gain,
    input  logic [zdf_pkg::CH_W-1:0]            channel,
    input  logic signed [zdf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [zdf_pkg::GAIN_W-1:0]          stage_gain,
    output logic [zdf_pkg::CH_W-1:0]            channel_out,
    output logic signed [zdf_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int ST_W   = zdf_pkg::ST_W;
    localparam int ACC_W  = zdf_pkg::ACC_W;

    logic [zdf_pkg::CH_W-1:0]            ch_reg;
    logic signed [zdf_pkg::SAMPLE_W-1:0] sample_reg;
    logic [zdf_pkg::GAIN_W-1:0]          gain_reg;
    logic                                bad_reg;
    logic                                rd_valid_reg;
    logic                                valid_reg [zdf_pkg::CHANNELS];
    logic signed [zdf_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ST_W-1:0]              x_reg;
    logic signed [ST_W-1:0]              s_reg [zdf_pkg::STAGES];
    logic [zdf_pkg::CH_W-1:0]            channel_out_reg;
    logic signed [zdf_pkg::SAMPLE_W-1:0] sample_out_reg;

    logic [zdf_pkg::STATE_WORD_W-1:0]    rdata;
    logic [zdf_pkg::STATE_WORD_W-1:0]    wdata;
    logic [zdf_pkg::ADDR_W-1:0]          waddr;
    logic signed [ST_W-1:0]              s_load [zdf_pkg::STAGES];
    logic signed [ST_W-1:0]              s_cur;
    logic [zdf_pkg::GAIN_W-1:0]          mul_gain;
    logic signed [zdf_pkg::DIFF_W-1:0]   mul_op;
    logic signed [zdf_pkg::GAIN_W:0]     mul_a;
    logic signed [zdf_pkg::PROD_W-1:0]   mul_p;
    logic signed [ST_W-1:0]              x_fb;
    logic signed [ST_W-1:0]              v_new;
    logic signed [ST_W-1:0]              s_new;

    assign waddr = zdf_pkg::to_addr(ch_reg);

    zdf_ram #(
        .WIDTH (zdf_pkg::STATE_WORD_W),
        .DEPTH (zdf_pkg::CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (cmd.wb && !bad_reg),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.load),
        .raddr (zdf_pkg::to_addr(channel)),
        .rdata (rdata)
    );

    // A channel never written reads as zero state.
    always_comb
    begin
        for (int k = 0; k < zdf_pkg::STAGES; k++)
        begin
            s_load[k] = rd_valid_reg ? $signed(rdata[k*ST_W +: ST_W]) : '0;
            wdata[k*ST_W +: ST_W] = s_reg[k];
        end
    end

    assign s_cur = s_reg[cmd.stage];

    // One shared multiplier: feedback gain times fourth state, or stage gain
    // times the difference between stage input and stage state.
    always_comb
    begin
        if (cmd.fb_mul)
        begin
            mul_gain = feedback_gain;
            mul_op   = $signed({s_load[zdf_pkg::STAGES-1][ST_W-1],
                                s_load[zdf_pkg::STAGES-1]});
        end
        else
        begin
            mul_gain = gain_reg;
            mul_op   = $signed({x_reg[ST_W-1], x_reg}) - $signed({s_cur[ST_W-1], s_cur});
        end
        mul_a = $signed({1'b0, mul_gain});
        mul_p = mul_a * mul_op;
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] smp;
        logic signed [ACC_W-1:0] vsum;
        logic signed [ACC_W-1:0] ssum;
        smp   = $signed({{(ACC_W - zdf_pkg::SAMPLE_W){sample_reg[zdf_pkg::SAMPLE_W-1]}},
                         sample_reg});
        x_fb  = zdf_pkg::sat_st(smp - zdf_pkg::round_q16(prod_reg));
        vsum  = zdf_pkg::ext_st(s_cur) + zdf_pkg::round_q16(prod_reg);
        v_new = zdf_pkg::sat_st(vsum);
        ssum  = (zdf_pkg::ext_st(v_new) <<< 1) - zdf_pkg::ext_st(s_cur);
        s_new = zdf_pkg::sat_st(ssum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            for (int c = 0; c < zdf_pkg::CHANNELS; c++)
            begin
                valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                bad_reg      <= !zdf_pkg::chan_ok(channel);
                rd_valid_reg <= zdf_pkg::chan_ok(channel) &&
                                valid_reg[zdf_pkg::to_addr(channel)];
            end
            if (cmd.wb && !bad_reg)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg     <= channel;
            sample_reg <= sample_in;
            gain_reg   <= stage_gain;
        end
        if (cmd.fb_mul)
        begin
            for (int k = 0; k < zdf_pkg::STAGES; k++)
            begin
                s_reg[k] <= s_load[k];
            end
        end
        if (cmd.fb_mul || cmd.st_mul)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.fb_sub)
        begin
            x_reg <= x_fb;
        end
        if (cmd.st_upd)
        begin
            x_reg             <= v_new;
            s_reg[cmd.stage]  <= s_new;
        end
        if (cmd.wb)
        begin
            channel_out_reg <= ch_reg;
            sample_out_reg  <= bad_reg ? '0 : zdf_pkg::sat_out(x_reg);
        end
    end

    assign status.chan_bad = bad_reg;
    assign channel_out     = channel_out_reg;
    assign sample_out      = sample_out_reg;

endmodule

// ===== rtl/zdf_ladder_lowpass_4pole.sv =====
// Channel        Handshake                        Payload
// input          in_valid / in_ready              channel, sample_in, stage_gain
// output         out_valid / out_ready            channel_out, sample_out
// configuration  psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// An input transfer is taken only in idle, so a new item starts only once the last one
// has left write-back. A valid channel's item runs feedback multiply, feedback subtract,
// a multiply and an update per stage, then write-back; an out-of-range channel's skips
// to write-back. Each multiplier use is followed by a step that rounds, adds and saturates.
// Reset clears all filter state at once through per-channel valid bits. A new input is
// taken while a result waits; a finished item stalls in write-back until that result goes.
module zdf_ladder_lowpass_4pole (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [zdf_pkg::CH_W-1:0]            channel,
    input  logic signed [zdf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [zdf_pkg::GAIN_W-1:0]          stage_gain,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [zdf_pkg::CH_W-1:0]            channel_out,
    output logic signed [zdf_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [zdf_pkg::PADDR_W-1:0]         paddr,
    input  logic [zdf_pkg::PDATA_W-1:0]         pwdata,
    output logic [zdf_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    logic [zdf_pkg::GAIN_W-1:0] feedback_gain_reg;
    logic [zdf_pkg::GAIN_W-1:0] feedback_gain_next;
    logic                       reg_index;
    zdf_pkg::dp_cmd_t           cmd;
    zdf_pkg::dp_status_t        status;

    // Registers sit on 32-bit words; the word index is the address above the
    // byte offset.
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    // A write transfer completes in the access phase of an APB cycle.
    always_comb
    begin
        feedback_gain_next = feedback_gain_reg;
        if (psel && penable && pwrite && pready && (reg_index == zdf_pkg::REG_FEEDBACK_GAIN))
        begin
            feedback_gain_next = pwdata[zdf_pkg::GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_gain_reg <= zdf_pkg::FEEDBACK_GAIN_RESET;
        end
        else
        begin
            feedback_gain_reg <= feedback_gain_next;
        end
    end

    // Reads of addresses beyond the register list return zero.
    always_comb
    begin
        prdata = '0;
        if (reg_index == zdf_pkg::REG_FEEDBACK_GAIN)
        begin
            prdata = zdf_pkg::PDATA_W'(feedback_gain_reg);
        end
    end

    // The controller sequences one item at a time through the datapath.
    zdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the per-channel state memory, the shared multiplier and
    // the result register.
    zdf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .feedback_gain (feedback_gain_reg),
        .channel       (channel),
        .sample_in     (sample_in),
        .stage_gain    (stage_gain),
        .channel_out   (channel_out),
        .sample_out    (sample_out)
    );

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zdf_pkg::*;

    // Each side leaves a cycle idle about this often, in percent.
    localparam int IDLE_PCT = 22;
    // The receiver holds off once, after this many results, for this many cycles.
    // The sender keeps offering items meanwhile, so the block fills up and stalls.
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 300;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 20;
    // Cycles without any transfer before the run is declared hung. The longest
    // correct pause is the receiver hold-off above plus one item of latency.
    localparam int STALL_LIMIT = 2000;

    // Register map: register i sits at byte address 4*i.
    localparam logic [PADDR_W-1:0] FEEDBACK_GAIN_ADDR = PADDR_W'(4 * REG_FEEDBACK_GAIN);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 16'h8000;
    localparam longint ST_MAX = (64'sd1 <<< (ST_W - 1)) - 1;
    localparam longint ST_MIN = -(64'sd1 <<< (ST_W - 1));
    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

    typedef struct {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
        logic [GAIN_W-1:0]          gain;
    } sample_item_t;

    typedef struct {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
    } filtered_t;

    // Every input of the block starts at a known value.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [CH_W-1:0]            channel = '0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic [GAIN_W-1:0]          stage_gain = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [CH_W-1:0]            channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // Items waiting to be offered, and filtered samples waiting to come out.
    sample_item_t sample_queue[$];
    filtered_t    filtered_q[$];
    sample_item_t next_item;
    filtered_t    want;

    // The predictor's own copy of the per-channel ladder states and the feedback gain.
    longint            ladder_state[STAGES][CHANNELS];
    logic [GAIN_W-1:0] fb_gain = FEEDBACK_GAIN_RESET;

    bit no_gaps = 1'b0;
    int errors = 0;
    int results_seen = 0;
    int hold_left = 0;

    zdf_ladder_lowpass_4pole dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample_in   (sample_in),
        .stage_gain  (stage_gain),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 clk = ~clk;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Q0.16 gain times a difference, rounded to nearest with halves going up.
    // The arithmetic shift of the biased product is a floor division by 2^16.
    function automatic longint gain_mul(input logic [GAIN_W-1:0] g, input longint d);
        longint gl;
        longint p;
        gl = g;
        p = gl * d + 32768;
        return p >>> FRAC_W;
    endfunction

    // Runs one sample through the channel's four-pole ladder and updates its states.
    // The input is first reduced by the feedback gain times the last stage state;
    // each stage then computes v = s + G*(x - s) and keeps 2v - s as its new state.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic [CH_W-1:0]            ch,
        input logic signed [SAMPLE_W-1:0] x_in,
        input logic [GAIN_W-1:0]          g
    );
        longint x;
        longint v;
        longint s;
        int     k;
        if (ch >= CHANNELS)
            return '0;
        x = x_in;
        x = clamp(x - gain_mul(fb_gain, ladder_state[STAGES-1][ch]), ST_MIN, ST_MAX);
        for (k = 0; k < STAGES; k++) begin
            s = ladder_state[k][ch];
            v = clamp(s + gain_mul(g, x - s), ST_MIN, ST_MAX);
            ladder_state[k][ch] = clamp(2 * v - s, ST_MIN, ST_MAX);
            x = v;
        end
        return SAMPLE_W'(clamp(x, OUT_MIN, OUT_MAX));
    endfunction

    // Driver: offers the next pending item whenever the current one has been
    // transferred, or leaves the cycle idle now and then. An item stays on the
    // bus unchanged until its transfer, and is predicted at that very edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                want.ch = channel;
                want.smp = filter_sample(channel, sample_in, stage_gain);
                filtered_q.insert(filtered_q.size(), want);
            end
            if (!in_valid || in_ready) begin
                if (sample_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                    next_item = sample_queue.pop_front();
                    in_valid <= 1'b1;
                    channel <= next_item.ch;
                    sample_in <= next_item.smp;
                    stage_gain <= next_item.gain;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction and
    // drives out_ready, with random idle cycles and one long hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got channel %0d sample %0d",
                             $time, channel_out, sample_out);
                    errors++;
                end
                else begin
                    want = filtered_q.pop_front();
                    if (channel_out !== want.ch) begin
                        $display("%0t: channel_out mismatch: expected %0d, got %0d",
                                 $time, want.ch, channel_out);
                        errors++;
                    end
                    if (sample_out !== want.smp) begin
                        $display("%0t: sample_out mismatch on channel %0d: expected %0d, got %0d",
                                 $time, want.ch, want.smp, sample_out);
                        errors++;
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run if nothing at all is transferred for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, filtered_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // One APB transfer: a setup cycle, then an access cycle that ends on pready.
    task automatic apb_cycle(input bit is_write, input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Reads the feedback gain back and compares it with the predictor's copy.
    task automatic check_feedback_gain();
        logic [PDATA_W-1:0] rdata;
        apb_cycle(1'b0, FEEDBACK_GAIN_ADDR, '0, rdata);
        if (rdata[GAIN_W-1:0] !== fb_gain) begin
            $display("%0t: feedback_gain readback mismatch: expected %0d, got %0d",
                     $time, fb_gain, rdata[GAIN_W-1:0]);
            errors++;
        end
    endtask

    // Writes a register; the upper data bits carry noise that the register drops.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [GAIN_W-1:0] value);
        logic [PDATA_W-1:0] rdata;
        logic [PDATA_W-1:0] data;
        data = $urandom();
        data[GAIN_W-1:0] = value;
        apb_cycle(1'b1, addr, data, rdata);
        if (addr == FEEDBACK_GAIN_ADDR)
            fb_gain = value;
        check_feedback_gain();
    endtask

    task automatic queue_item(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp,
                              input logic [GAIN_W-1:0] g);
        sample_item_t it;
        it.ch = ch;
        it.smp = smp;
        it.gain = g;
        sample_queue.insert(sample_queue.size(), it);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return SMP_MAX;
        if (pick < 16)
            return SMP_MIN;
        if (pick < 30)
            return SAMPLE_W'(int'($urandom_range(127)) - 64);
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return '0;
        if (pick < 12)
            return GAIN_MAX;
        if (pick < 25)
            return GAIN_W'($urandom_range(255));
        return GAIN_W'($urandom());
    endfunction

    // Each random pick is, with equal odds, a single scattered sample or a burst
    // of a square wave on one channel at a fixed gain; the bursts are what drive
    // the ladder and its feedback loop into large swings and state saturation.
    task automatic queue_random_items(input int count);
        int                         n;
        int                         k;
        int                         burst;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] amp;
        logic [GAIN_W-1:0]          g;
        n = 0;
        while (n < count) begin
            if ($urandom_range(1) == 0) begin
                queue_item(CH_W'($urandom_range(CHANNELS - 1)), random_sample(), random_gain());
                n++;
            end
            else begin
                ch = CH_W'($urandom_range(CHANNELS - 1));
                amp = random_sample();
                g = random_gain();
                burst = $urandom_range(4, 12);
                for (k = 0; k < burst; k++)
                    queue_item(ch, (k % 2 == 0) ? amp : -amp, g);
                n += burst;
            end
        end
    endtask

    // Waits, from the falling edge, until everything queued has been transferred
    // and every result has come out, then lets the pipeline settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || filtered_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        int c;
        int k;
        for (k = 0; k < STAGES; k++)
            for (c = 0; c < CHANNELS; c++)
                ladder_state[k][c] = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The feedback gain must come out of reset at its documented value.
        check_feedback_gain();

        // Directed samples at the reset feedback gain. Full-scale steps with a
        // gain near one push the states into saturation; a gain of one half with
        // odd inputs lands products exactly on a rounding half; a zero gain holds
        // the stages still; every channel gets at least one sample.
        @(negedge clk);
        for (k = 0; k < 3; k++)
            queue_item(0, SMP_MAX, GAIN_MAX);
        for (k = 0; k < 3; k++)
            queue_item(0, SMP_MIN, GAIN_MAX);
        queue_item(1, 0, 0);
        queue_item(1, -1, GAIN_HALF);
        queue_item(1, 1, GAIN_HALF);
        queue_item(1, 3, GAIN_HALF);
        queue_item(2, SMP_MAX, 1);
        queue_item(2, SMP_MIN, 0);
        queue_item(3, -1, GAIN_MAX);
        queue_item(4, 1, 1);
        queue_item(5, SMP_MAX, GAIN_HALF);
        queue_item(6, SMP_MIN, GAIN_HALF);
        for (k = 0; k < 6; k++)
            queue_item(7, (k % 2 == 0) ? SMP_MAX : SMP_MIN, GAIN_MAX);
        wait_idle();

        // No feedback at all: the ladder is four plain one-pole stages.
        write_reg(FEEDBACK_GAIN_ADDR, '0);
        @(negedge clk);
        queue_random_items(270);
        wait_idle();

        // Largest feedback, with both sides running flat out.
        write_reg(FEEDBACK_GAIN_ADDR, GAIN_MAX);
        @(negedge clk);
        no_gaps = 1'b1;
        queue_random_items(270);
        wait_idle();
        no_gaps = 1'b0;

        // A write past the register list must leave the feedback gain alone.
        // The long receiver hold-off falls inside this phase.
        write_reg(UNMAPPED_ADDR, GAIN_W'($urandom()));
        write_reg(FEEDBACK_GAIN_ADDR, GAIN_W'($urandom()));
        @(negedge clk);
        queue_random_items(270);
        wait_idle();

        write_reg(FEEDBACK_GAIN_ADDR, FEEDBACK_GAIN_RESET);
        @(negedge clk);
        queue_random_items(270);
        wait_idle();

        write_reg(FEEDBACK_GAIN_ADDR, GAIN_W'($urandom()));
        @(negedge clk);
        queue_random_items(300);
        wait_idle();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
